// ===== rtl/qrs_pkg.sv =====
// shared types and constants for the quadratic root solver
package qrs_pkg;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_LIN,
    MODE_DBL,
    MODE_TWO
  } mode_t;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int COEF_WIDTH_DEF = 32;
  localparam int TOL_WIDTH      = 16;

endpackage

// ===== rtl/qrs_sqrt.sv =====
// pipelined integer square root, one root bit per stage
module qrs_sqrt #(
  parameter int W   = 32,
  parameter int PLW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [2*W:0]   d,
  input  logic [PLW-1:0] in_pl,
  output logic           out_valid,
  output logic [W:0]     root,
  output logic [PLW-1:0] out_pl
);
  localparam int SW  = W + 1;
  localparam int RW  = SW + 3;
  localparam int RMW = RW - 2;
  localparam int XW  = 2 * SW;

  logic           v      [SW];
  logic [RMW-1:0] rem    [SW];
  logic [SW-1:0]  rt     [SW];
  logic [XW-1:0]  dx     [SW];
  logic [PLW-1:0] pl     [SW];

  logic           v_next   [SW];
  logic [RMW-1:0] rem_next [SW];
  logic [SW-1:0]  rt_next  [SW];
  logic [XW-1:0]  dx_next  [SW];
  logic [PLW-1:0] pl_next  [SW];

  always_comb begin
    logic           pv;
    logic [RMW-1:0] prem;
    logic [SW-1:0]  prt;
    logic [XW-1:0]  pdx;
    logic [PLW-1:0] ppl;
    logic [RW-1:0]  rsh;
    logic [RW-1:0]  trial;
    for (int k = 0; k < SW; k++) begin
      if (k == 0) begin
        pv   = in_valid;
        prem = '0;
        prt  = '0;
        pdx  = XW'(d);
        ppl  = in_pl;
      end else begin
        pv   = v[k-1];
        prem = rem[k-1];
        prt  = rt[k-1];
        pdx  = dx[k-1];
        ppl  = pl[k-1];
      end
      // bring down two bits, try root*4+1
      rsh   = {prem, pdx[XW-1 -: 2]};
      trial = RW'({prt, 2'b01});
      v_next[k]  = pv;
      dx_next[k] = {pdx[XW-3:0], 2'b00};
      pl_next[k] = ppl;
      if (rsh >= trial) begin
        rem_next[k] = RMW'(rsh - trial);
        rt_next[k]  = {prt[SW-2:0], 1'b1};
      end else begin
        rem_next[k] = rsh[RMW-1:0];
        rt_next[k]  = {prt[SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SW; k++) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v_next[k];
      end
      if (en) begin
        rem[k] <= rem_next[k];
        rt[k]  <= rt_next[k];
        dx[k]  <= dx_next[k];
        pl[k]  <= pl_next[k];
      end
    end
  end

  assign out_valid = v[SW-1];
  assign root      = rt[SW-1];
  assign out_pl    = pl[SW-1];

endmodule

// ===== rtl/qrs_div.sv =====
// pipelined restoring divider, two quotients over a shared divisor, one bit per stage
module qrs_div #(
  parameter int NW  = 52,
  parameter int DDW = 34,
  parameter int PLW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [NW-1:0]  n1,
  input  logic [NW-1:0]  n2,
  input  logic [DDW-1:0] den,
  input  logic [PLW-1:0] in_pl,
  output logic           out_valid,
  output logic [NW-1:0]  q1,
  output logic [NW-1:0]  q2,
  output logic [PLW-1:0] out_pl
);
  logic           v  [NW];
  logic [DDW-1:0] r1 [NW];
  logic [DDW-1:0] r2 [NW];
  logic [NW-1:0]  x1 [NW];
  logic [NW-1:0]  x2 [NW];
  logic [DDW-1:0] dn [NW];
  logic [PLW-1:0] pl [NW];

  logic           v_next  [NW];
  logic [DDW-1:0] r1_next [NW];
  logic [DDW-1:0] r2_next [NW];
  logic [NW-1:0]  x1_next [NW];
  logic [NW-1:0]  x2_next [NW];
  logic [DDW-1:0] dn_next [NW];
  logic [PLW-1:0] pl_next [NW];

  always_comb begin
    logic           pv;
    logic [DDW-1:0] pr1;
    logic [DDW-1:0] pr2;
    logic [NW-1:0]  px1;
    logic [NW-1:0]  px2;
    logic [DDW-1:0] pdn;
    logic [PLW-1:0] ppl;
    logic [DDW:0]   s1;
    logic [DDW:0]   s2;
    logic           ge1;
    logic           ge2;
    for (int k = 0; k < NW; k++) begin
      if (k == 0) begin
        pv  = in_valid;
        pr1 = '0;
        pr2 = '0;
        px1 = n1;
        px2 = n2;
        pdn = den;
        ppl = in_pl;
      end else begin
        pv  = v[k-1];
        pr1 = r1[k-1];
        pr2 = r2[k-1];
        px1 = x1[k-1];
        px2 = x2[k-1];
        pdn = dn[k-1];
        ppl = pl[k-1];
      end
      s1  = {pr1, px1[NW-1]};
      s2  = {pr2, px2[NW-1]};
      ge1 = s1 >= {1'b0, pdn};
      ge2 = s2 >= {1'b0, pdn};
      r1_next[k] = ge1 ? DDW'(s1 - {1'b0, pdn}) : s1[DDW-1:0];
      r2_next[k] = ge2 ? DDW'(s2 - {1'b0, pdn}) : s2[DDW-1:0];
      // dividend bits shift out the top, quotient bits shift in below
      x1_next[k] = {px1[NW-2:0], ge1};
      x2_next[k] = {px2[NW-2:0], ge2};
      v_next[k]  = pv;
      dn_next[k] = pdn;
      pl_next[k] = ppl;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NW; k++) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v_next[k];
      end
      if (en) begin
        r1[k] <= r1_next[k];
        r2[k] <= r2_next[k];
        x1[k] <= x1_next[k];
        x2[k] <= x2_next[k];
        dn[k] <= dn_next[k];
        pl[k] <= pl_next[k];
      end
    end
  end

  assign out_valid = v[NW-1];
  assign q1        = x1[NW-1];
  assign q2        = x2[NW-1];
  assign out_pl    = pl[NW-1];

endmodule

// ===== rtl/quadratic_root_solver_unit.sv =====
// top level of the quadratic root solver
// Solves a*x^2+b*x+c=0 for signed fixed-point coefficients and returns a
// root count with up to two roots. One request enters per clock while
// in_stall is low. Each request passes through the square root pipeline
// (COEF_WIDTH+1 stages, one root bit per stage) and the divider pipeline
// (COEF_WIDTH+FRAC_BITS+4 stages, one quotient bit per stage) placed back to
// back, plus the input, product, discriminant, numerator and output registers.
// A stalled output holds every stage, so the input stalls with it.
// zero_tolerance is written through cfg_write/cfg_data; the user must write
// it only while idle, as the block does not enforce this.
module quadratic_root_solver_unit #(
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF,
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [qrs_pkg::TOL_WIDTH-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [31:0]             coef_a,
  input  logic signed [31:0]             coef_b,
  input  logic signed [31:0]             coef_c,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     root_count,
  output logic signed [31:0]             first_root,
  output logic signed [31:0]             second_root,
  output logic                           overflow
);
  import qrs_pkg::*;

  localparam int W   = COEF_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int DW  = 2 * W + 1;
  localparam int NUW = W + 3;
  localparam int NW  = W + F + 4;
  localparam int DDW = W + 2;
  localparam int SPL = 3 * W + 4;
  localparam int DPL = 6;
  localparam longint UNU = (F >= W - 1) ? -(longint'(1) << (W - 1)) : -(longint'(1) << F);
  localparam logic [W-1:0] UNUSED_R = W'(UNU);
  localparam logic [NW-1:0] QMAX = NW'((longint'(1) << (W - 1)) - 1);

  logic en;
  logic [TOL_WIDTH-1:0] zero_tolerance;
  logic [TOL_WIDTH-1:0] tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_tolerance <= TOL_WIDTH'(1);
    end else if (cfg_write) begin
      zero_tolerance <= cfg_data;
    end
  end

  assign tol      = (zero_tolerance == '0) ? TOL_WIDTH'(1) : zero_tolerance;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // input stage
  logic v0;
  logic signed [W-1:0] a0, b0, c0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
    if (en) begin
      a0 <= coef_a[W-1:0];
      b0 <= coef_b[W-1:0];
      c0 <= coef_c[W-1:0];
    end
  end

  // magnitudes, zero tests, products
  logic [W-1:0] ma, mb, mc;
  logic v1, za1, zb1, zc1;
  logic signed [W-1:0] a1, b1, c1;
  logic [2*W-1:0] sq1, pac1;

  assign ma = a0[W-1] ? W'(-a0) : W'(a0);
  assign mb = b0[W-1] ? W'(-b0) : W'(b0);
  assign mc = c0[W-1] ? W'(-c0) : W'(c0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
    if (en) begin
      a1   <= a0;
      b1   <= b0;
      c1   <= c0;
      za1  <= ma < W'(tol);
      zb1  <= mb < W'(tol);
      zc1  <= mc < W'(tol);
      sq1  <= (2*W)'(mb) * (2*W)'(mb);
      pac1 <= (2*W)'(ma) * (2*W)'(mc);
    end
  end

  // discriminant and case selection
  logic [DW-1:0] sqx, p4x, dd, tolw;
  logic ac_pos, sq_ge, dneg;
  mode_t mode_c;
  logic [1:0] cnt_c;

  assign sqx    = DW'(sq1);
  assign p4x    = DW'({pac1, 2'b00});
  assign ac_pos = (a1[W-1] == c1[W-1]) && (c1 != '0);
  assign sq_ge  = sqx >= p4x;
  assign dneg   = ac_pos && !sq_ge;
  assign dd     = !ac_pos ? DW'(sqx + p4x) : (sq_ge ? DW'(sqx - p4x) : DW'(p4x - sqx));
  assign tolw   = DW'(tol);

  always_comb begin
    mode_c = MODE_NONE;
    cnt_c  = CNT_NONE;
    if (za1) begin
      if (zb1) begin
        cnt_c = zc1 ? CNT_INF : CNT_NONE;
      end else begin
        mode_c = MODE_LIN;
        cnt_c  = CNT_ONE;
      end
    end else if (dneg && dd >= tolw) begin
      cnt_c = CNT_NONE;
    end else if (dd < tolw) begin
      mode_c = MODE_DBL;
      cnt_c  = CNT_ONE;
    end else begin
      mode_c = MODE_TWO;
      cnt_c  = CNT_TWO;
    end
  end

  logic v2;
  logic [DW-1:0] d2;
  logic [SPL-1:0] pl2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      d2  <= dd;
      pl2 <= {a1, b1, c1, mode_c, cnt_c};
    end
  end

  logic sv;
  logic [W:0] sroot;
  logic [SPL-1:0] spl;

  qrs_sqrt #(.W(W), .PLW(SPL)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .d         (d2),
    .in_pl     (pl2),
    .out_valid (sv),
    .root      (sroot),
    .out_pl    (spl)
  );

  // numerators and divisor
  logic signed [W-1:0] as, bs, cs;
  mode_t smode;
  logic [1:0] scnt;
  logic signed [NUW-1:0] ax, bx, cx, sx, num1, num2, dnm;
  logic [NUW-2:0] m1, m2;
  logic [W:0] dmag;

  assign as    = spl[SPL-1 -: W];
  assign bs    = spl[SPL-1-W -: W];
  assign cs    = spl[SPL-1-2*W -: W];
  assign smode = mode_t'(spl[3:2]);
  assign scnt  = spl[1:0];
  assign ax    = NUW'(as);
  assign bx    = NUW'(bs);
  assign cx    = NUW'(cs);
  assign sx    = signed'(NUW'(sroot));

  always_comb begin
    num1 = -bx;
    num2 = -bx;
    dnm  = ax <<< 1;
    case (smode)
      MODE_LIN: begin
        num1 = -cx;
        dnm  = bx;
      end
      MODE_TWO: begin
        num1 = -bx + sx;
        num2 = -bx - sx;
      end
      default: begin
        num1 = -bx;
      end
    endcase
  end

  assign m1   = num1[NUW-1] ? (NUW-1)'(-num1) : (NUW-1)'(num1);
  assign m2   = num2[NUW-1] ? (NUW-1)'(-num2) : (NUW-1)'(num2);
  assign dmag = dnm[NUW-1] ? (W+1)'(-dnm) : (W+1)'(dnm);

  logic v3;
  logic [NW-1:0] n1r, n2r;
  logic [DDW-1:0] dr;
  logic [DPL-1:0] pl3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= sv;
    end
    if (en) begin
      // (n << (F+1)) + |den| over 2|den| rounds half away from zero
      n1r <= NW'({m1, (F+1)'(0)}) + NW'(dmag);
      n2r <= NW'({m2, (F+1)'(0)}) + NW'(dmag);
      dr  <= {dmag, 1'b0};
      pl3 <= {num1[NUW-1] ^ dnm[NUW-1], num2[NUW-1] ^ dnm[NUW-1], smode, scnt};
    end
  end

  logic dv;
  logic [NW-1:0] q1, q2;
  logic [DPL-1:0] dpl;

  qrs_div #(.NW(NW), .DDW(DDW), .PLW(DPL)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .n1        (n1r),
    .n2        (n2r),
    .den       (dr),
    .in_pl     (pl3),
    .out_valid (dv),
    .q1        (q1),
    .q2        (q2),
    .out_pl    (dpl)
  );

  // sign, saturation; returns {overflow, value}
  function automatic logic [W:0] fin(input logic [NW-1:0] q, input logic neg);
    logic [W:0] res;
    if (neg) begin
      if (q > NW'(QMAX + NW'(1))) begin
        res = {1'b1, 1'b1, {(W-1){1'b0}}};
      end else begin
        res = {1'b0, W'(-q)};
      end
    end else begin
      if (q > QMAX) begin
        res = {1'b1, 1'b0, {(W-1){1'b1}}};
      end else begin
        res = {1'b0, W'(q)};
      end
    end
    return res;
  endfunction

  logic [W:0] f1, f2;
  mode_t fmode;
  logic [W-1:0] r1, r2;
  logic ovf;

  assign f1    = fin(q1, dpl[5]);
  assign f2    = fin(q2, dpl[4]);
  assign fmode = mode_t'(dpl[3:2]);

  always_comb begin
    r1  = UNUSED_R;
    r2  = UNUSED_R;
    ovf = 1'b0;
    case (fmode)
      MODE_LIN, MODE_DBL: begin
        r1  = f1[W-1:0];
        ovf = f1[W];
      end
      MODE_TWO: begin
        r1  = f1[W-1:0];
        r2  = f2[W-1:0];
        ovf = f1[W] | f2[W];
      end
      default: begin
        ovf = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv;
    end
    if (en) begin
      root_count  <= dpl[1:0];
      first_root  <= 32'(signed'(r1));
      second_root <= 32'(signed'(r2));
      overflow    <= ovf;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the quadratic root solver unit
`timescale 1ns / 1ps

module testbench;
  import qrs_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 90;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } coef_set_t;

  typedef struct {
    logic [1:0]         count;
    logic signed [31:0] r1;
    logic signed [31:0] r2;
    logic               ovf;
  } root_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [TOL_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_accepted = 1'b0;
  logic signed [31:0] coef_a = '0, coef_b = '0, coef_c = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] root_count;
  logic signed [31:0] first_root, second_root;
  logic overflow;

  coef_set_t pending_sets[$];
  root_set_t expected_roots[$];
  logic [15:0] tol_reg = 16'd1;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int solved = 0;
  longint cycles = 0;

  quadratic_root_solver_unit i_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .out_valid(out_valid), .out_stall(out_stall),
    .root_count(root_count), .first_root(first_root),
    .second_root(second_root), .overflow(overflow)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] magn(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint sat32(longint v, inout logic ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // rounded fixed-point quotient, ties away from zero
  function automatic longint fix_div(longint num, longint den, inout logic ovf);
    logic [127:0] n, dm, q;
    n = 128'(magn(num));
    dm = 128'(magn(den));
    q = ((n << (FRAC + 1)) + dm) / (dm << 1);
    if (q > 128'h7FFF_FFFF_FFFF) begin
      ovf = 1'b1;
      return ((num < 0) != (den < 0)) ? -64'sd2147483648 : 64'sd2147483647;
    end
    return sat32(((num < 0) != (den < 0)) ? -longint'(q) : longint'(q), ovf);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [127:0] d);
    logic [63:0] r, t;
    r = '0;
    for (int bitpos = 34; bitpos >= 0; bitpos--) begin
      t = r | (64'd1 << bitpos);
      if (128'(t) * 128'(t) <= d) r = t;
    end
    return r;
  endfunction

  function automatic root_set_t solve_roots(coef_set_t s, logic [15:0] tol_cfg);
    root_set_t res;
    longint a, b, c, r1, r2;
    logic [63:0] tol;
    logic [127:0] sq, p4, d;
    logic ovf, dneg;
    a = s.a;
    b = s.b;
    c = s.c;
    tol = (tol_cfg == 0) ? 64'd1 : 64'(tol_cfg);
    r1 = -(64'sd1 << FRAC);
    r2 = r1;
    ovf = 1'b0;
    dneg = 1'b0;
    if (magn(a) < tol) begin
      if (magn(b) < tol) begin
        res.count = (magn(c) < tol) ? CNT_INF : CNT_NONE;
      end else begin
        res.count = CNT_ONE;
        r1 = fix_div(-c, b, ovf);
      end
    end else begin
      sq = 128'(magn(b)) * 128'(magn(b));
      p4 = (128'(magn(a)) * 128'(magn(c))) << 2;
      if (!((a < 0) == (c < 0) && c != 0)) d = sq + p4;
      else if (sq >= p4) d = sq - p4;
      else begin
        d = p4 - sq;
        dneg = 1'b1;
      end
      if (dneg && d >= 128'(tol)) begin
        res.count = CNT_NONE;
      end else if (d < 128'(tol)) begin
        res.count = CNT_ONE;
        r1 = fix_div(-b, 2 * a, ovf);
      end else begin
        res.count = CNT_TWO;
        r1 = fix_div(-b + longint'(int_sqrt(d)), 2 * a, ovf);
        r2 = fix_div(-b - longint'(int_sqrt(d)), 2 * a, ovf);
      end
    end
    res.r1 = r1[31:0];
    res.r2 = r2[31:0];
    res.ovf = ovf;
    return res;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_accepted) begin
        if (in_accepted) void'(pending_sets.pop_front());
        if (pending_sets.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          coef_a <= pending_sets[0].a;
          coef_b <= pending_sets[0].b;
          coef_c <= pending_sets[0].c;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // predict on accept, check results
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_accepted <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall)
      expected_roots.push_back(solve_roots('{coef_a, coef_b, coef_c}, tol_reg));
    if (!rst && out_valid && !out_stall) begin
      if (expected_roots.size() == 0) begin
        $display("%0t: unexpected result count=%0d", $time, root_count);
        errors++;
      end else begin
        root_set_t e;
        e = expected_roots.pop_front();
        solved++;
        if (root_count !== e.count) begin
          $display("%0t: root_count exp %0d got %0d", $time, e.count, root_count);
          errors++;
        end
        if (first_root !== e.r1) begin
          $display("%0t: first_root exp %h got %h", $time, e.r1, first_root);
          errors++;
        end
        if (second_root !== e.r2) begin
          $display("%0t: second_root exp %h got %h", $time, e.r2, second_root);
          errors++;
        end
        if (overflow !== e.ovf) begin
          $display("%0t: overflow exp %0d got %0d", $time, e.ovf, overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("quadratic_root_solver_unit test failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(7))
      0: return 32'($urandom_range(3)) - 32'd1;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'($signed(16'($urandom)));
      3: return 32'(signed'(20'($urandom)));
      4: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)} << 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    while (pending_sets.size() > 0 || in_valid || expected_roots.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic set_tolerance(logic [15:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    tol_reg = v;
  endtask

  task automatic add_set(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    pending_sets.push_back('{a, b, c});
  endtask

  initial begin
    logic [15:0] tol_list[6];
    tol_list = '{16'd1, 16'hFFFF, 16'd0, 16'd300, 16'd1, 16'($urandom)};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: degenerate, linear, double, two, none, extremes
    add_set(0, 0, 0);
    add_set(0, 0, 32'h0001_0000);
    add_set(0, 32'h0002_0000, 32'h0001_0000);
    add_set(0, 32'h0000_0001, 32'h7FFF_FFFF);
    add_set(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    add_set(32'h0001_0000, 0, 32'hFFFF_0000);
    add_set(32'h0001_0000, 0, 32'h0001_0000);
    add_set(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_set(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_set(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_set(32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF);
    add_set(32'hFFFF_FFFF, 32'h0000_0001, 0);
    add_set(32'h0000_0001, 32'h0000_0002, 32'h0000_0001);
    add_set(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      set_tolerance(tol_list[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 56; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 56; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      for (int k = 0; k < 160; k++)
        add_set(($urandom_range(9) == 0) ? 32'($urandom_range(2)) : pick_coef(),
                pick_coef(), pick_coef());
      drain();
    end
    $display("solved %0d coefficient sets over six tolerance settings", solved);
    $display("covered degenerate, linear, double, two-root and saturating cases");
    if (errors == 0) begin
      $display("quadratic_root_solver_unit test passed");
    end else begin
      $display("quadratic_root_solver_unit test failed");
    end
    $finish;
  end

endmodule
